>>> src/msc_pkg.sv
`default_nettype none
package msc_pkg;

  // fixed field widths
  localparam int COORD_W  = 16;
  localparam int DIFF_W   = COORD_W + 1;
  localparam int SUM_W    = COORD_W + 2;
  localparam int PROD_W   = 2 * DIFF_W;
  localparam int NORM_W   = PROD_W;
  localparam int HALF_W   = NORM_W / 2;
  localparam int SQ_W     = 2 * NORM_W;
  localparam int REM_W    = NORM_W + 3;
  localparam int WSUM_W   = 64;
  localparam int AREA_W   = 48;
  localparam int DEN_W    = AREA_W + 3;
  localparam int NUM_W    = WSUM_W + 2;
  localparam int QUO_W    = 17;
  localparam int DSH_W    = DEN_W + QUO_W;
  localparam int IN_DATA_W  = 9 * COORD_W;
  localparam int OUT_DATA_W = 3 * COORD_W;

  // parameter defaults
  localparam int COORD_BITS_DEF    = 16;
  localparam int MAX_TRIANGLES_DEF = 4096;
  localparam int QUEUE_DEPTH       = 2;

  // one classified triangle between front and back
  typedef struct packed {
    logic signed [DIFF_W-1:0] ux;
    logic signed [DIFF_W-1:0] uy;
    logic signed [DIFF_W-1:0] uz;
    logic signed [DIFF_W-1:0] vx;
    logic signed [DIFF_W-1:0] vy;
    logic signed [DIFF_W-1:0] vz;
    logic signed [SUM_W-1:0]  sx;
    logic signed [SUM_W-1:0]  sy;
    logic signed [SUM_W-1:0]  sz;
    logic                     acc;
    logic                     last;
    logic                     ovf;
  } tri_t;

endpackage
`default_nettype wire

>>> src/msc_fifo.sv
`default_nettype none
module msc_fifo
  import msc_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  wire  clk,
  input  wire  rst_n,
  input  wire  push,
  input  tri_t wr_data,
  output logic full,
  input  wire  pop,
  output logic empty,
  output tri_t rd_data
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  tri_t             mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [CNT_W-1:0] count_r;

  assign full    = (count_r == CNT_W'(DEPTH));
  assign empty   = (count_r == '0);
  assign rd_data = mem_r[rd_ptr_r];

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

>>> src/msc_front.sv
`default_nettype none
module msc_front
  import msc_pkg::*;
#(
  parameter int COORD_BITS    = COORD_BITS_DEF,
  parameter int MAX_TRIANGLES = MAX_TRIANGLES_DEF
) (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  in_tvalid,
  output logic                 in_tready,
  input  wire [IN_DATA_W-1:0]  in_tdata,
  input  wire                  in_tlast,
  input  wire                  q_full,
  output logic                 q_push,
  output tri_t                 q_data
);

  localparam int SH    = COORD_W - COORD_BITS;
  localparam int CNT_W = $clog2(MAX_TRIANGLES + 2);

  logic signed [COORD_W-1:0] c   [9];
  logic signed [COORD_W-1:0] shl [9];
  logic [CNT_W-1:0]          cnt_r;
  logic [CNT_W-1:0]          cnt_inc;

  assign in_tready = !q_full;
  assign q_push    = in_tvalid && !q_full;

  // keep the low coordinate bits, sign-extended
  always_comb begin
    for (int i = 0; i < 9; i++) begin
      shl[i] = $signed(in_tdata[i*COORD_W +: COORD_W] << SH);
      c[i]   = shl[i] >>> SH;
    end
  end

  // edge vectors, vertex sums and count tags
  always_comb begin
    cnt_inc   = (cnt_r <= CNT_W'(MAX_TRIANGLES)) ? cnt_r + 1'b1 : cnt_r;
    q_data.ux = DIFF_W'(c[3]) - DIFF_W'(c[0]);
    q_data.uy = DIFF_W'(c[4]) - DIFF_W'(c[1]);
    q_data.uz = DIFF_W'(c[5]) - DIFF_W'(c[2]);
    q_data.vx = DIFF_W'(c[6]) - DIFF_W'(c[0]);
    q_data.vy = DIFF_W'(c[7]) - DIFF_W'(c[1]);
    q_data.vz = DIFF_W'(c[8]) - DIFF_W'(c[2]);
    q_data.sx = SUM_W'(c[0]) + SUM_W'(c[3]) + SUM_W'(c[6]);
    q_data.sy = SUM_W'(c[1]) + SUM_W'(c[4]) + SUM_W'(c[7]);
    q_data.sz = SUM_W'(c[2]) + SUM_W'(c[5]) + SUM_W'(c[8]);
    q_data.acc  = (cnt_r < CNT_W'(MAX_TRIANGLES));
    q_data.last = in_tlast;
    q_data.ovf  = (cnt_inc > CNT_W'(MAX_TRIANGLES));
  end

  // triangle count, cleared after the last of a mesh
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (q_push) begin
      cnt_r <= in_tlast ? '0 : cnt_inc;
    end
  end

endmodule
`default_nettype wire

>>> src/msc_back.sv
`default_nettype none
module msc_back
  import msc_pkg::*;
(
  input  wire                   clk,
  input  wire                   rst_n,
  input  wire                   q_empty,
  input  tri_t                  q_data,
  output logic                  q_pop,
  output logic                  out_tvalid,
  input  wire                   out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,
  output logic                  out_tuser
);

  typedef enum logic [3:0] {
    S_IDLE, S_CROSS, S_SQUARE, S_ROOT, S_WEIGHT, S_CHECK,
    S_DLOAD, S_DCHK, S_DSTEP, S_DFIN, S_EMIT
  } state_t;

  state_t                    state_r;
  tri_t                      item_r;
  logic [5:0]                step_r;
  logic [1:0]                axis_r;
  logic [1:0]                part_r;
  logic signed [PROD_W-1:0]  prod_r;
  logic [NORM_W-1:0]         n_r [3];
  logic [SQ_W-1:0]           sq_r;
  logic [REM_W-1:0]          rem_r;
  logic [NORM_W-1:0]         root_r;
  logic [WSUM_W-1:0]         wsum_r [3];
  logic [AREA_W-1:0]         area_r;
  logic [DEN_W-1:0]          d_r;
  logic [NUM_W-1:0]          num_r;
  logic [DSH_W-1:0]          dsh_r;
  logic [QUO_W-1:0]          quo_r;
  logic                      neg_r;
  logic [COORD_W-1:0]        cen_r [3];
  logic                      degen_r;
  logic                      out_valid_r;
  logic [OUT_DATA_W-1:0]     out_data_r;
  logic                      out_user_r;

  logic signed [DIFF_W-1:0]  cr_a, cr_b;
  logic signed [PROD_W-1:0]  cr_p;
  logic signed [PROD_W:0]    cr_d;
  logic [NORM_W-1:0]         cr_mag;
  logic [HALF_W-1:0]         sq_a, sq_b;
  logic [NORM_W-1:0]         sq_p;
  logic [SQ_W-1:0]           sq_add;
  logic [REM_W-1:0]          rt_sh, rt_trial;
  logic signed [SUM_W-1:0]   wt_s;
  logic signed [NORM_W+SUM_W:0] wt_p;
  logic [WSUM_W-1:0]         dv_w, dv_m;
  logic [DEN_W-1:0]          d_six;
  logic [COORD_W-1:0]        dv_res;
  logic                      out_free;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;
  assign out_free   = !out_valid_r || out_tready;
  assign q_pop      = (state_r == S_IDLE) && !q_empty;

  // cross product operands, one product per cycle
  always_comb begin
    case (step_r[2:0])
      3'd0:    begin cr_a = item_r.uy; cr_b = item_r.vz; end
      3'd1:    begin cr_a = item_r.uz; cr_b = item_r.vy; end
      3'd2:    begin cr_a = item_r.uz; cr_b = item_r.vx; end
      3'd3:    begin cr_a = item_r.ux; cr_b = item_r.vz; end
      3'd4:    begin cr_a = item_r.ux; cr_b = item_r.vy; end
      default: begin cr_a = item_r.uy; cr_b = item_r.vx; end
    endcase
    cr_p   = cr_a * cr_b;
    cr_d   = {prod_r[PROD_W-1], prod_r} - {cr_p[PROD_W-1], cr_p};
    cr_mag = cr_d[PROD_W] ? NORM_W'(-cr_d) : NORM_W'(cr_d);
  end

  // squared norm as half-word partial products
  always_comb begin
    case (part_r)
      2'd0:    begin sq_a = n_r[axis_r][HALF_W-1:0];
                     sq_b = n_r[axis_r][HALF_W-1:0]; end
      2'd1:    begin sq_a = n_r[axis_r][NORM_W-1:HALF_W];
                     sq_b = n_r[axis_r][HALF_W-1:0]; end
      default: begin sq_a = n_r[axis_r][NORM_W-1:HALF_W];
                     sq_b = n_r[axis_r][NORM_W-1:HALF_W]; end
    endcase
    sq_p = sq_a * sq_b;
    case (part_r)
      2'd0:    sq_add = SQ_W'(sq_p);
      2'd1:    sq_add = SQ_W'(sq_p) << (HALF_W + 1);
      default: sq_add = SQ_W'(sq_p) << NORM_W;
    endcase
  end

  // square root, two radicand bits per cycle
  always_comb begin
    rt_sh    = {rem_r[REM_W-3:0], sq_r[SQ_W-1 -: 2]};
    rt_trial = {1'b0, root_r, 2'b01};
  end

  // area weighting
  always_comb begin
    case (step_r[1:0])
      2'd0:    wt_s = item_r.sx;
      2'd1:    wt_s = item_r.sy;
      default: wt_s = item_r.sz;
    endcase
    wt_p = $signed({1'b0, root_r}) * wt_s;
  end

  // division setup and result saturation
  always_comb begin
    dv_w  = wsum_r[axis_r];
    dv_m  = dv_w[WSUM_W-1] ? (~dv_w) + 1'b1 : dv_w;
    d_six = DEN_W'({area_r, 2'b00}) + DEN_W'({area_r, 1'b0});
    if (!neg_r) begin
      dv_res = (quo_r > QUO_W'(32767)) ? 16'h7fff : quo_r[COORD_W-1:0];
    end else begin
      dv_res = (quo_r > QUO_W'(32768)) ? 16'h8000
                                       : (~quo_r[COORD_W-1:0]) + 1'b1;
    end
  end

  // sequencer with datapath registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      area_r      <= '0;
      for (int i = 0; i < 3; i++) wsum_r[i] <= '0;
    end else begin
      if (out_valid_r && out_tready && state_r != S_EMIT) out_valid_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (!q_empty) begin
            item_r  <= q_data;
            step_r  <= '0;
            state_r <= q_data.acc ? S_CROSS : S_CHECK;
          end
        end
        S_CROSS: begin
          if (!step_r[0]) prod_r <= cr_p;
          else n_r[step_r[2:1]] <= cr_mag;
          step_r <= step_r + 1'b1;
          if (step_r == 6'd5) begin
            sq_r    <= '0;
            axis_r  <= '0;
            part_r  <= '0;
            state_r <= S_SQUARE;
          end
        end
        S_SQUARE: begin
          sq_r <= sq_r + sq_add;
          if (part_r == 2'd2) begin
            part_r <= '0;
            axis_r <= axis_r + 1'b1;
            if (axis_r == 2'd2) begin
              rem_r   <= '0;
              root_r  <= '0;
              step_r  <= '0;
              state_r <= S_ROOT;
            end
          end else begin
            part_r <= part_r + 1'b1;
          end
        end
        S_ROOT: begin
          sq_r <= sq_r << 2;
          if (rt_sh >= rt_trial) begin
            rem_r  <= rt_sh - rt_trial;
            root_r <= {root_r[NORM_W-2:0], 1'b1};
          end else begin
            rem_r  <= rt_sh;
            root_r <= {root_r[NORM_W-2:0], 1'b0};
          end
          if (step_r == 6'(NORM_W - 1)) begin
            step_r  <= '0;
            state_r <= S_WEIGHT;
          end else begin
            step_r <= step_r + 1'b1;
          end
        end
        S_WEIGHT: begin
          wsum_r[step_r[1:0]] <= wsum_r[step_r[1:0]]
                                 + {{(WSUM_W-NORM_W-SUM_W-1){wt_p[NORM_W+SUM_W]}}, wt_p};
          if (step_r == 6'd0) area_r <= area_r + AREA_W'(root_r);
          step_r <= step_r + 1'b1;
          if (step_r == 6'd2) state_r <= S_CHECK;
        end
        S_CHECK: begin
          if (!item_r.last) begin
            state_r <= S_IDLE;
          end else if (item_r.ovf || area_r == '0) begin
            for (int i = 0; i < 3; i++) cen_r[i] <= '0;
            degen_r <= 1'b1;
            state_r <= S_EMIT;
          end else begin
            d_r     <= d_six;
            axis_r  <= '0;
            degen_r <= 1'b0;
            state_r <= S_DLOAD;
          end
        end
        S_DLOAD: begin
          neg_r   <= dv_w[WSUM_W-1];
          num_r   <= NUM_W'({dv_m, 1'b0}) + NUM_W'(d_r[DEN_W-1:1]);
          dsh_r   <= DSH_W'(d_r) << (QUO_W - 1);
          quo_r   <= '0;
          step_r  <= '0;
          state_r <= S_DCHK;
        end
        S_DCHK: begin
          // quotient too large for the iteration: saturate
          if (DSH_W'(num_r) >= (DSH_W'(d_r) << QUO_W)) begin
            quo_r   <= '1;
            state_r <= S_DFIN;
          end else begin
            state_r <= S_DSTEP;
          end
        end
        S_DSTEP: begin
          if (DSH_W'(num_r) >= dsh_r) begin
            num_r <= NUM_W'(DSH_W'(num_r) - dsh_r);
            quo_r <= {quo_r[QUO_W-2:0], 1'b1};
          end else begin
            quo_r <= {quo_r[QUO_W-2:0], 1'b0};
          end
          dsh_r  <= dsh_r >> 1;
          step_r <= step_r + 1'b1;
          if (step_r == 6'(QUO_W - 1)) state_r <= S_DFIN;
        end
        S_DFIN: begin
          cen_r[axis_r] <= dv_res;
          axis_r        <= axis_r + 1'b1;
          state_r       <= (axis_r == 2'd2) ? S_EMIT : S_DLOAD;
        end
        S_EMIT: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            out_data_r  <= {cen_r[2], cen_r[1], cen_r[0]};
            out_user_r  <= degen_r;
            area_r      <= '0;
            for (int i = 0; i < 3; i++) wsum_r[i] <= '0;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

>>> src/mesh_surface_centroid.sv
`default_nettype none
// mesh_surface_centroid: area-weighted centroid of a triangle surface mesh
//
// in_*  : one triangle per request; tdata holds ax, ay, az, bx, by, bz, cx,
//         cy, cz (16 bits each, lowest first), tlast marks the last triangle
// out_* : one result per mesh after its last triangle; tdata holds
//         centroid_x, centroid_y, centroid_z, tuser is the degenerate flag
//
// the front stage forms edge vectors, vertex sums and the triangle count
// and writes them to a two-entry queue; the back stage works on one
// triangle at a time: it takes it, then forms the cross products, the squared
// norm, the square root, the weighting and the check; its throughput is bound
// by the shared multipliers and the root iteration
// the last triangle adds the three divisions (a saturated one ends early)
// and the registering of the result on out_*
// reset empties the queue, clears the count and all sums, drops out_tvalid
// a stalled receiver holds the result in the output register; the back
// stage waits once its next result is ready, the queue fills and in_tready falls
module mesh_surface_centroid
  import msc_pkg::*;
#(
  parameter int COORD_BITS    = COORD_BITS_DEF,
  parameter int MAX_TRIANGLES = MAX_TRIANGLES_DEF
) (
  input  wire                   clk,
  input  wire                   rst_n,
  input  wire                   in_tvalid,
  output logic                  in_tready,
  input  wire [IN_DATA_W-1:0]   in_tdata,   // ax, ay, az, bx, by, bz, cx, cy, cz
  input  wire                   in_tlast,   // last_triangle
  output logic                  out_tvalid,
  input  wire                   out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,  // centroid_x, centroid_y, centroid_z
  output logic                  out_tuser   // degenerate
);

  logic q_push, q_pop, q_full, q_empty;
  tri_t q_wr, q_rd;

  msc_front #(
    .COORD_BITS    (COORD_BITS),
    .MAX_TRIANGLES (MAX_TRIANGLES)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_data    (q_wr)
  );

  msc_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (q_push),
    .wr_data (q_wr),
    .full    (q_full),
    .pop     (q_pop),
    .empty   (q_empty),
    .rd_data (q_rd)
  );

  msc_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_empty    (q_empty),
    .q_data     (q_rd),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule
`default_nettype wire

>>> src/msc_checker.sv
`default_nettype none
module msc_checker
  import msc_pkg::*;
(
  input wire                  clk,
  input wire                  rst_n,
  input wire                  out_tvalid,
  input wire                  out_tready,
  input wire [OUT_DATA_W-1:0] out_tdata,
  input wire                  out_tuser
);

  // a stalled result stays offered
  a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result dropped while stalled");

  // a stalled result keeps its payload
  a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

  // a degenerate mesh reports the origin
  a_degen_origin: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tdata == '0)
    else $error("degenerate result not at origin");

  // nothing is offered right after reset
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result offered after reset");

endmodule

bind mesh_surface_centroid msc_checker u_msc_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);
`default_nettype wire

>>> test/mesh_surface_centroid_tb.sv
`timescale 1ns / 100ps
`default_nettype none
module mesh_surface_centroid_tb;
  import msc_pkg::*;

  localparam int MAX_TRI = MAX_TRIANGLES_DEF;

  typedef struct packed {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic signed [15:0] z;
  } vtx_t;

  typedef struct {
    vtx_t a;
    vtx_t b;
    vtx_t c;
    logic last;
  } tri_req_t;

  typedef struct {
    logic [15:0] cx;
    logic [15:0] cy;
    logic [15:0] cz;
    logic        degen;
  } centroid_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [IN_DATA_W-1:0] in_tdata = '0;  // ax, ay, az, bx, by, bz, cx, cy, cz
  logic in_tlast = 1'b0;                // last_triangle
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;     // centroid_x, centroid_y, centroid_z
  logic out_tuser;                      // degenerate

  mesh_surface_centroid uut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready),
    .in_tdata(in_tdata), .in_tlast(in_tlast),
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata), .out_tuser(out_tuser)
  );

  always #5 clk = ~clk;

  tri_req_t  pending_tris[$];
  centroid_t expected_centroids[$];
  int        error_count = 0;
  bit        hold_sender = 1'b0;

  // running mesh sums
  logic signed [63:0] wsum_x = 0, wsum_y = 0, wsum_z = 0;
  logic [47:0] area_sum = 0;
  int unsigned tri_count = 0;

  function automatic logic [15:0] round_axis(logic [63:0] num, logic [50:0] den);
    logic        neg;
    logic [63:0] m;
    logic [66:0] q;
    neg = num[63];
    m = neg ? (~num + 64'd1) : num;
    q = ({3'b0, m} * 2 + den) / ({16'b0, den} * 2);
    if (!neg && q > 32767) q = 32767;
    if (neg && q > 32768) q = 32768;
    return neg ? 16'(-q) : q[15:0];
  endfunction

  // twice the triangle area, floor of the cross product length
  function automatic logic [35:0] double_area(tri_req_t t);
    logic signed [63:0] ux, uy, uz, vx, vy, vz, nx, ny, nz;
    logic [127:0] sq, p;
    logic [35:0] r, tr;
    ux = t.b.x - t.a.x; uy = t.b.y - t.a.y; uz = t.b.z - t.a.z;
    vx = t.c.x - t.a.x; vy = t.c.y - t.a.y; vz = t.c.z - t.a.z;
    nx = uy * vz - uz * vy;
    ny = uz * vx - ux * vz;
    nz = ux * vy - uy * vx;
    sq = 128'(nx) * 128'(nx) + 128'(ny) * 128'(ny) + 128'(nz) * 128'(nz);
    r = 0;
    for (int bitn = 35; bitn >= 0; bitn--) begin
      tr = r | (36'd1 << bitn);
      p = 128'(tr) * 128'(tr);
      if (p <= sq) r = tr;
    end
    return r;
  endfunction

  task automatic enqueue_tri(tri_req_t t);
    pending_tris.insert(pending_tris.size(), t);
  endtask

  task automatic predict_triangle(tri_req_t t);
    logic [35:0] a2;
    logic signed [63:0] sa;
    centroid_t res;
    if (tri_count < MAX_TRI) begin
      a2 = double_area(t);
      sa = {28'b0, a2};
      wsum_x += sa * (64'(t.a.x) + 64'(t.b.x) + 64'(t.c.x));
      wsum_y += sa * (64'(t.a.y) + 64'(t.b.y) + 64'(t.c.y));
      wsum_z += sa * (64'(t.a.z) + 64'(t.b.z) + 64'(t.c.z));
      area_sum += 48'(a2);
    end
    if (tri_count <= MAX_TRI) tri_count++;
    if (t.last) begin
      if (area_sum == 0 || tri_count > MAX_TRI) begin
        res = '{16'd0, 16'd0, 16'd0, 1'b1};
      end else begin
        res.cx = round_axis(wsum_x, 51'(area_sum) * 3);
        res.cy = round_axis(wsum_y, 51'(area_sum) * 3);
        res.cz = round_axis(wsum_z, 51'(area_sum) * 3);
        res.degen = 1'b0;
      end
      expected_centroids.insert(expected_centroids.size(), res);
      wsum_x = 0; wsum_y = 0; wsum_z = 0; area_sum = 0; tri_count = 0;
    end
  endtask

  task automatic report_mismatch(string what, logic [15:0] got, logic [15:0] want);
    $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
    error_count++;
  endtask

  function automatic vtx_t rand_vtx(int span);
    vtx_t v;
    if (span >= 32768) begin
      v = {16'($urandom), 16'($urandom), 16'($urandom)};
    end else begin
      v.x = 16'($signed($urandom_range(2 * span)) - span);
      v.y = 16'($signed($urandom_range(2 * span)) - span);
      v.z = 16'($signed($urandom_range(2 * span)) - span);
    end
    return v;
  endfunction

  function automatic tri_req_t mk_tri(vtx_t a, vtx_t b, vtx_t c, logic last);
    tri_req_t t;
    t.a = a; t.b = b; t.c = c; t.last = last;
    return t;
  endfunction

  // driver: bursts with random gaps
  int gap_left = 0, burst_left = 0;
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) predict_triangle(pending_tris.pop_front());
      if (in_tvalid && !in_tready) begin
        // hold current request
      end else if (pending_tris.size() > (in_tvalid && in_tready ? 1 : 0) - 1 &&
                   pending_tris.size() != 0 && !hold_sender && gap_left == 0) begin
        in_tvalid <= 1'b1;
        in_tdata <= {pending_tris[0].c.z, pending_tris[0].c.y, pending_tris[0].c.x,
                     pending_tris[0].b.z, pending_tris[0].b.y, pending_tris[0].b.x,
                     pending_tris[0].a.z, pending_tris[0].a.y, pending_tris[0].a.x};
        in_tlast <= pending_tris[0].last;
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 20);
          gap_left = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 12);
        end else begin
          burst_left--;
        end
      end else begin
        in_tvalid <= 1'b0;
        if (gap_left > 0) gap_left--;
      end
    end
  end

  // receiver stall pattern and result check
  int stall_phase = 0;
  always @(posedge clk) begin
    centroid_t want;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        if (expected_centroids.size() == 0) begin
          $display("unexpected result %0h at %0t", out_tdata, $realtime);
          error_count++;
        end else begin
          want = expected_centroids.pop_front();
          if (out_tdata[15:0] !== want.cx) report_mismatch("centroid_x", out_tdata[15:0], want.cx);
          if (out_tdata[31:16] !== want.cy) report_mismatch("centroid_y", out_tdata[31:16], want.cy);
          if (out_tdata[47:32] !== want.cz) report_mismatch("centroid_z", out_tdata[47:32], want.cz);
          if (out_tuser !== want.degen) report_mismatch("degenerate", 16'(out_tuser), 16'(want.degen));
        end
      end
      stall_phase = (stall_phase + 1) % 400;
      if (stall_phase < 100) out_tready <= 1'b1;
      else if (stall_phase < 300) out_tready <= ($urandom_range(2) != 0);
      else out_tready <= ($urandom_range(9) == 0);
    end
  end

  task automatic queue_mesh(int ntri, int span);
    for (int i = 0; i < ntri; i++)
      enqueue_tri(mk_tri(rand_vtx(span), rand_vtx(span), rand_vtx(span), i == ntri - 1));
  endtask

  task automatic wait_drained();
    while (pending_tris.size() != 0 || in_tvalid || expected_centroids.size() != 0)
      @(posedge clk);
  endtask

  initial begin
    vtx_t o, px, py, mx, mn;
    int n, spans[4];
    spans = '{32768, 1000, 30, 3};
    o = '0; px = {16'sd0, 16'sd0, 16'sd10}; py = {16'sd0, 16'sd10, 16'sd0};
    mx = {16'sh7fff, 16'sh7fff, 16'sh7fff}; mn = {16'sh8000, 16'sh8000, 16'sh8000};
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // directed: simple, zero area, extremes, saturation
    enqueue_tri(mk_tri(o, px, py, 1'b1));
    enqueue_tri(mk_tri(o, o, o, 1'b1));
    enqueue_tri(mk_tri(px, px, py, 1'b0));
    enqueue_tri(mk_tri(o, o, py, 1'b1));
    enqueue_tri(mk_tri(mx, {16'sh7fff, 16'sh8000, 16'sh7fff},
                       {16'sh8000, 16'sh7fff, 16'sh7fff}, 1'b1));
    enqueue_tri(mk_tri(mn, {16'sh8000, 16'sh7fff, 16'sh8000},
                       {16'sh7fff, 16'sh8000, 16'sh8000}, 1'b1));
    enqueue_tri(mk_tri(mn, {16'sh7fff, 16'sh8000, 16'sh0},
                       {16'sh8000, 16'sh7fff, 16'sh7fff}, 1'b0));
    enqueue_tri(mk_tri(o, px, py, 1'b1));
    enqueue_tri(mk_tri({16'sh7fff, 16'sh8000, 16'sh7fff},
                       {16'sh8000, 16'sh7fff, 16'sh8000}, mx, 1'b1));
    // rounding: centroid of (0,0,0),(0,0,1),(0,1,0) and of its mirror image
    enqueue_tri(mk_tri(o, {16'sd0, 16'sd0, 16'sd1},
                       {16'sd0, 16'sd1, 16'sd0}, 1'b1));
    enqueue_tri(mk_tri(o, {16'sd0, 16'sd0, -16'sd1},
                       {16'sd0, -16'sd1, 16'sd0}, 1'b1));
    wait_drained();

    // pause the sender once all results have come
    hold_sender = 1'b1;
    repeat (20) @(posedge clk);
    hold_sender = 1'b0;

    // random meshes: mostly small, some degenerate
    n = 0;
    while (n < 1440) begin
      int k;
      k = $urandom_range(1, 12);
      if ($urandom_range(9) == 0)
        for (int i = 0; i < k; i++)
          enqueue_tri(mk_tri(o, px, px, i == k - 1));
      else
        queue_mesh(k, spans[$urandom_range(3)]);
      n += k;
    end
    wait_drained();
    repeat (200) @(posedge clk);
    if (error_count == 0 && expected_centroids.size() == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

  initial begin
    #40ms;
    $display("*** FAILED ***");
    $finish;
  end

endmodule
`default_nettype wire

>>> sim.f
src/msc_pkg.sv
src/msc_fifo.sv
src/msc_front.sv
src/msc_back.sv
src/mesh_surface_centroid.sv
src/msc_checker.sv
test/mesh_surface_centroid_tb.sv
